>>> src/sxma_pkg.sv
// ----------------------------------------------------------------------------
// sxma_pkg
// Shared types and constants of the XOR-mapped-address parser.
// ----------------------------------------------------------------------------
package sxma_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned PortW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CntW    = 5;
  localparam int unsigned RemW    = 17;
  localparam int unsigned VidxW   = 3;

  // Cookie and attribute code of XOR-MAPPED-ADDRESS
  localparam logic [AddrW-1:0] STUN_COOKIE  = 32'h2112A442;
  localparam logic [PortW-1:0] XMA_TYPE     = 16'h0020;
  // Last byte position of the fixed STUN header
  localparam logic [CntW-1:0]  HDR_LAST_IDX = 5'd19;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_AHDR    = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_CAPTURE = 5'b01000,
    PH_IGNORE  = 5'b10000
  } sxma_phase_t;

  // One datagram byte with its end marker
  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
  } sxma_byte_t;

endpackage

>>> src/sxma_in_if.sv
// ----------------------------------------------------------------------------
// sxma_in_if
// Byte channel into the parser: valid/ready with data byte and end marker.
// ----------------------------------------------------------------------------
interface sxma_in_if import sxma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/sxma_out_if.sv
// ----------------------------------------------------------------------------
// sxma_out_if
// Result channel of the parser: valid/ready with the decoded mapping.
// ----------------------------------------------------------------------------
interface sxma_out_if import sxma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic             too_short;
  logic [DataW-1:0] addr_family;
  logic [PortW-1:0] public_port;
  logic [AddrW-1:0] public_addr;

  modport source (output valid, output found, output too_short, output addr_family,
                  output public_port, output public_addr, input ready);
  modport sink   (input valid, input found, input too_short, input addr_family,
                  input public_port, input public_addr, output ready);
endinterface

>>> src/sxma_in_reg.sv
// ----------------------------------------------------------------------------
// sxma_in_reg
// Input register: holds one byte transfer until the parser takes it.
// ----------------------------------------------------------------------------
module sxma_in_reg import sxma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sxma_in_if.sink    in_ch,
  input  logic       take,
  output logic       hold_valid,
  output sxma_byte_t hold_byte
);

  logic       valid_r;
  logic       valid_nxt;
  sxma_byte_t byte_r;
  logic       load;

  // Accept a new byte when empty or when the held one leaves this cycle
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r.data_byte <= in_ch.data_byte;
      byte_r.last_byte <= in_ch.last_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

>>> src/sxma_parser.sv
// ----------------------------------------------------------------------------
// sxma_parser
// Attribute walker and result register: one byte per cycle; a final byte waits while the last result is untaken.
// ----------------------------------------------------------------------------
module sxma_parser import sxma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       hold_valid,
  input  sxma_byte_t hold_byte,
  output logic       take,
  sxma_out_if.source out_ch
);

  sxma_phase_t      phase_r,  phase_nxt;
  logic [CntW-1:0]  cnt_r,    cnt_nxt;
  logic [PortW-1:0] type_r,   type_nxt;
  logic [RemW-1:0]  rem_r,    rem_nxt;
  logic [VidxW-1:0] vidx_r,   vidx_nxt;
  logic [DataW-1:0] family_r, family_nxt;
  logic [PortW-1:0] port_r,   port_nxt;
  logic [AddrW-1:0] addr_r,   addr_nxt;
  logic             match_r,  match_nxt;

  logic             out_valid_r;
  logic             found_r;
  logic             short_r;
  logic [DataW-1:0] res_family_r;
  logic [PortW-1:0] res_port_r;
  logic [AddrW-1:0] res_addr_r;

  logic             out_free;
  logic             emit;
  logic [DataW-1:0] b;
  logic [RemW-1:0]  len_sum;

  assign b        = hold_byte.data_byte;
  assign out_free = !out_valid_r || out_ch.ready;
  // A non-final byte never needs the result slot
  assign take     = hold_valid && (!hold_byte.last_byte || out_free);
  assign emit     = take && hold_byte.last_byte;
  assign len_sum  = (rem_r | {{(RemW-DataW){1'b0}}, b}) + RemW'(3);

  // Advance the parse state by one byte
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    type_nxt   = type_r;
    rem_nxt    = rem_r;
    vidx_nxt   = vidx_r;
    family_nxt = family_r;
    port_nxt   = port_r;
    addr_nxt   = addr_r;
    match_nxt  = match_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (cnt_r == HDR_LAST_IDX) begin
          cnt_nxt   = '0;
          phase_nxt = PH_AHDR;
        end else begin
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      PH_AHDR: begin
        cnt_nxt = cnt_r + CntW'(1);
        unique case (cnt_r[1:0])
          2'd0: type_nxt = {b, 8'h00};
          2'd1: type_nxt = {type_r[15:8], b};
          2'd2: rem_nxt  = {1'b0, b, 8'h00};
          default: begin
            // Round the length up to a whole word
            rem_nxt = {len_sum[RemW-1:2], 2'b00};
            cnt_nxt = '0;
            if (type_r == XMA_TYPE) begin
              vidx_nxt  = '0;
              phase_nxt = PH_CAPTURE;
            end else if (rem_nxt != '0) begin
              phase_nxt = PH_SKIP;
            end
          end
        endcase
      end
      PH_SKIP: begin
        rem_nxt = rem_r - RemW'(1);
        if (rem_nxt == '0) begin
          phase_nxt = PH_AHDR;
        end
      end
      PH_CAPTURE: begin
        // Reserved byte first, then family, port, address
        if (vidx_r == 3'd1) begin
          family_nxt = b;
        end else if (vidx_r == 3'd2 || vidx_r == 3'd3) begin
          port_nxt = {port_r[7:0], b};
        end else if (vidx_r[2]) begin
          addr_nxt = {addr_r[23:0], b};
        end
        vidx_nxt = vidx_r + VidxW'(1);
        if (vidx_r == 3'd7) begin
          match_nxt = 1'b1;
          phase_nxt = PH_IGNORE;
        end
      end
      default: begin
      end
    endcase
  end

  // Update state; the final byte of a datagram returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      type_r   <= '0;
      rem_r    <= '0;
      vidx_r   <= '0;
      family_r <= '0;
      port_r   <= '0;
      addr_r   <= '0;
      match_r  <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      type_r   <= type_nxt;
      rem_r    <= rem_nxt;
      vidx_r   <= vidx_nxt;
      family_r <= family_nxt;
      port_r   <= port_nxt;
      addr_r   <= addr_nxt;
      match_r  <= match_nxt;
    end
  end

  // Result valid: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, decoded with the cookie
  always_ff @(posedge clk) begin
    if (emit) begin
      found_r      <= match_nxt;
      short_r      <= (phase_nxt == PH_HEADER);
      res_family_r <= match_nxt ? family_nxt : '0;
      res_port_r   <= match_nxt ? (port_nxt ^ STUN_COOKIE[31:16]) : '0;
      res_addr_r   <= match_nxt ? (addr_nxt ^ STUN_COOKIE) : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.too_short   = short_r;
  assign out_ch.addr_family = res_family_r;
  assign out_ch.public_port = res_port_r;
  assign out_ch.public_addr = res_addr_r;

  a_found_not_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_r |-> !short_r)
    else $error("found and too_short both set");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> res_family_r == '0 && res_port_r == '0 && res_addr_r == '0)
    else $error("fields not cleared without a match");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> phase_r == PH_HEADER && cnt_r == '0 && !match_r)
    else $error("state not cleared after final byte");

  a_match_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> phase_r == PH_IGNORE)
    else $error("match flagged outside ignore phase");

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> cnt_r <= HDR_LAST_IDX)
    else $error("header count out of range");

endmodule

>>> src/stun_xor_mapped_address_parser_top.sv
// ----------------------------------------------------------------------------
// stun_xor_mapped_address_parser_top
// STUN response parser that extracts the XOR-MAPPED-ADDRESS attribute.
// ----------------------------------------------------------------------------
// Feed the datagram one byte per transfer, with last_byte set on its final
// byte. The block skips the 20-byte header, walks the padded attributes and
// captures the first XOR-MAPPED-ADDRESS whose eight value bytes all arrive.
// Each byte passes an input register, then one step of the attribute walker,
// and the final byte loads the result register. The block sustains one byte
// per clock but for one stall: a result waits in its register while the
// next datagram's bytes keep flowing; only a final byte stalls while the
// previous result is still untaken.
// ----------------------------------------------------------------------------
module stun_xor_mapped_address_parser_top import sxma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sxma_in_if.sink     in_ch,
  sxma_out_if.source  out_ch
);

  logic       hold_valid;
  logic       take;
  sxma_byte_t hold_byte;

  // Input register
  sxma_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // Attribute walker with result register
  sxma_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

>>> sim/tb_stun_xor_mapped_address_parser_top.sv
// ----------------------------------------------------------------------------
// tb_stun_xor_mapped_address_parser_top
// Self-checking bench for the STUN XOR-MAPPED-ADDRESS parser.
// ----------------------------------------------------------------------------
// Datagrams are sent one byte per transfer. A built-in attribute walker
// computes the result expected for each final byte, and every result is
// checked in order against it. A directed set of datagrams comes first:
// short packets, bare header, field extremes, truncated attributes, short
// declared length, second match and large skips. Random datagrams follow.
// Most are well formed with random content; the rest are short, truncated
// or pure noise. Random gaps stall both the byte and the result channels.
// ----------------------------------------------------------------------------
module tb_stun_xor_mapped_address_parser_top;
  import sxma_pkg::*;

  localparam int unsigned RandomBytes = 1500;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned NumProbes   = 15;
  localparam int unsigned MaxReports  = 50;

  // One decoded mapping, as it leaves the parser
  typedef struct packed {
    logic             found;
    logic             too_short;
    logic [DataW-1:0] addr_family;
    logic [PortW-1:0] public_port;
    logic [AddrW-1:0] public_addr;
  } mapping_t;

  localparam mapping_t NO_MAP    = '0;
  localparam mapping_t SHORT_MAP = '{1'b0, 1'b1, 8'h00, 16'h0000, 32'h0};
  localparam mapping_t ONES_MAP  = '{1'b1, 1'b0, 8'h01, 16'hDEED, 32'hDEED_5BBD};
  localparam mapping_t ZERO_MAP  = '{1'b1, 1'b0, 8'hFF, 16'h2112, 32'h2112_A442};

  // Directed datagram: 20 header bytes of fill, up to two attributes,
  // then cut or padded with fill to a total length (0 keeps the natural length)
  typedef struct {
    int unsigned      cut;
    logic [7:0]       fill;
    int unsigned      n_attr;
    logic [15:0]      t0;
    logic [15:0]      l0;
    logic [15:0]      t1;
    logic [15:0]      l1;
    logic [7:0]       fam;
    logic [15:0]      rport;
    logic [31:0]      raddr;
    bit               typed;
    mapping_t         want;
  } probe_t;

  probe_t probes [NumProbes] = '{
    // one byte, 19 bytes: short datagram
    '{ 1, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 1, SHORT_MAP},
    '{19, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, SHORT_MAP},
    // header alone
    '{20, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, NO_MAP},
    // match with all-ones and all-zeros raw values
    '{ 0, 8'h00, 1, XMA_TYPE, 8, 0, 0, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 1, ONES_MAP},
    '{ 0, 8'hFF, 1, XMA_TYPE, 8, 0, 0, 8'hFF, 16'h0000, 32'h0000_0000, 1, ZERO_MAP},
    // padded skip, then zero-length skip, before the match
    '{ 0, 8'hA5, 2, 16'h0001, 5, XMA_TYPE, 8, 8'h01, 16'h1234, 32'hC0A8_0001, 0, NO_MAP},
    '{ 0, 8'h5A, 2, 16'h8022, 0, XMA_TYPE, 12, 8'h02, 16'hBEEF, 32'h2001_0DB8, 0, NO_MAP},
    // match declared with length zero still captures eight bytes
    '{ 0, 8'h00, 1, XMA_TYPE, 0, 0, 0, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 1, ONES_MAP},
    // attribute header cut off, match value cut off
    '{22, 8'h00, 1, XMA_TYPE, 8, 0, 0, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 1, NO_MAP},
    '{31, 8'hFF, 1, XMA_TYPE, 8, 0, 0, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 1, NO_MAP},
    // second match must be ignored
    '{ 0, 8'h3C, 2, XMA_TYPE, 8, XMA_TYPE, 8, 8'h01, 16'h0102, 32'h0304_0506, 0, NO_MAP},
    // largest declared length, cut by the end of the datagram
    '{40, 8'hFF, 1, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 1, NO_MAP},
    // near-miss attribute types
    '{ 0, 8'h00, 2, 16'h2000, 4, 16'h0021, 8, 0, 0, 0, 1, NO_MAP},
    // match followed by more attributes and trailing fill
    '{60, 8'h77, 2, XMA_TYPE, 8, 16'h0001, 20, 8'h01, 16'hA5A5, 32'h5A5A_5A5A, 0, NO_MAP},
    // empty attribute and nothing else
    '{24, 8'h00, 1, 16'h0003, 0, 0, 0, 0, 0, 0, 1, NO_MAP}
  };

  int unsigned stage_gap   [4] = '{0, 20, 50, 10};
  int unsigned stage_stall [4] = '{0, 20, 50, 70};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             byte_valid = 1'b0;
  logic [DataW-1:0] byte_data  = '0;
  logic             byte_last  = 1'b0;
  logic             res_ready  = 1'b0;

  sxma_in_if  in_ch ();
  sxma_out_if out_ch ();

  assign in_ch.valid     = byte_valid;
  assign in_ch.data_byte = byte_data;
  assign in_ch.last_byte = byte_last;
  assign out_ch.ready    = res_ready;

  stun_xor_mapped_address_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Attribute walker state
  sxma_phase_t      walk_phase;
  logic [CntW-1:0]  walk_cnt;
  logic [15:0]      walk_type;
  logic [RemW-1:0]  walk_left;
  logic [3:0]       walk_vidx;
  logic [7:0]       cap_family;
  logic [PortW-1:0] cap_port;
  logic [AddrW-1:0] cap_addr;
  logic             cap_done;

  mapping_t    pending_maps [$];
  logic [7:0]  dgram [$];
  int unsigned dgram_cap;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned found_count = 0;
  int unsigned short_count = 0;
  int unsigned dgrams_sent = 0;
  int unsigned bytes_sent = 0;

  function void clear_walker();
    walk_phase = PH_HEADER;
    walk_cnt   = '0;
    walk_type  = '0;
    walk_left  = '0;
    walk_vidx  = '0;
    cap_family = '0;
    cap_port   = '0;
    cap_addr   = '0;
    cap_done   = 1'b0;
  endfunction

  // Advance the walker by one datagram byte
  function void walk_byte(input logic [7:0] b);
    logic [RemW-1:0] sum;
    unique case (walk_phase)
      PH_HEADER: begin
        if (walk_cnt == HDR_LAST_IDX) begin
          walk_cnt   = '0;
          walk_phase = PH_AHDR;
        end else begin
          walk_cnt = walk_cnt + 5'd1;
        end
      end
      PH_AHDR: begin
        unique case (walk_cnt)
          0: walk_type = {b, 8'h00};
          1: walk_type[7:0] = b;
          2: walk_left = {1'b0, b, 8'h00};
          default: begin
            sum       = {1'b0, walk_left[15:8], b} + 17'd3;
            walk_left = {sum[RemW-1:2], 2'b00};
          end
        endcase
        if (walk_cnt == 3) begin
          walk_cnt = '0;
          if (walk_type == XMA_TYPE) begin
            walk_vidx  = '0;
            walk_phase = PH_CAPTURE;
          end else if (walk_left != 0) begin
            walk_phase = PH_SKIP;
          end
        end else begin
          walk_cnt = walk_cnt + 5'd1;
        end
      end
      PH_SKIP: begin
        walk_left = walk_left - 17'd1;
        if (walk_left == 0) walk_phase = PH_AHDR;
      end
      PH_CAPTURE: begin
        if (walk_vidx == 1) cap_family = b;
        else if (walk_vidx == 2 || walk_vidx == 3) cap_port = {cap_port[7:0], b};
        else if (walk_vidx >= 4) cap_addr = {cap_addr[23:0], b};
        walk_vidx = walk_vidx + 4'd1;
        if (walk_vidx == 8) begin
          cap_done   = 1'b1;
          walk_phase = PH_IGNORE;
        end
      end
      default: ;
    endcase
  endfunction

  // Report the datagram that just ended and rearm for the next one
  function mapping_t close_dgram();
    mapping_t m;
    m = '0;
    m.too_short = (walk_phase == PH_HEADER);
    if (cap_done) begin
      m.found       = 1'b1;
      m.addr_family = cap_family;
      m.public_port = cap_port ^ STUN_COOKIE[31:16];
      m.public_addr = cap_addr ^ STUN_COOKIE;
    end
    clear_walker();
    return m;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function void put(input logic [7:0] b);
    if (dgram_cap == 0 || dgram.size() < dgram_cap) dgram.push_back(b);
  endfunction

  // Append one attribute; a match always carries its eight value bytes
  function void add_attr(input logic [15:0] atype, input logic [15:0] alen,
                         input logic [7:0] fam, input logic [15:0] rport,
                         input logic [31:0] raddr, input logic [7:0] pad);
    int unsigned span;
    span = (int'(alen) + 3) / 4 * 4;
    put(atype[15:8]);
    put(atype[7:0]);
    put(alen[15:8]);
    put(alen[7:0]);
    if (atype == XMA_TYPE) begin
      put(8'h00);
      put(fam);
      put(rport[15:8]);
      put(rport[7:0]);
      for (int k = 3; k >= 0; k--) put(raddr[8*k +: 8]);
      span = (span > 8) ? span - 8 : 0;
    end
    for (int k = 0; k < span; k++) put(pad);
  endfunction

  function void build_probe(input probe_t p);
    dgram.delete();
    dgram_cap = p.cut;
    for (int k = 0; k < 20; k++) put(p.fill);
    if (p.n_attr > 0) add_attr(p.t0, p.l0, p.fam, p.rport, p.raddr, p.fill);
    if (p.n_attr > 1) begin
      if (p.t0 == XMA_TYPE)
        add_attr(p.t1, p.l1, p.fill, {2{p.fill}}, {4{p.fill}}, p.fill);
      else
        add_attr(p.t1, p.l1, p.fam, p.rport, p.raddr, p.fill);
    end
    while (dgram_cap != 0 && dgram.size() < dgram_cap) dgram.push_back(p.fill);
  endfunction

  // Mostly well-formed responses with random content; some short, cut or noise
  function void build_random();
    int unsigned r;
    int unsigned n_attr;
    int unsigned cut;
    logic [15:0] atype;
    logic [15:0] alen;
    dgram.delete();
    dgram_cap = 0;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(64, 1)) put(8'($urandom_range(255)));
    end else if (r < 14) begin
      repeat ($urandom_range(19, 1)) put(8'($urandom_range(255)));
    end else begin
      for (int k = 0; k < 20; k++) put(8'($urandom_range(255)));
      n_attr = $urandom_range(3);
      repeat (n_attr) begin
        r = $urandom_range(99);
        if (r < 40)      atype = XMA_TYPE;
        else if (r < 55) atype = 16'h0001;
        else if (r < 70) atype = 16'h8022;
        else             atype = 16'($urandom_range(16'hFFFF));
        r = $urandom_range(99);
        if (r < 90)      alen = 16'($urandom_range(16));
        else if (r < 95) alen = 16'($urandom_range(7));
        else             alen = 16'($urandom_range(300, 17));
        add_attr(atype, alen, ($urandom_range(3) != 0) ? 8'h01 : 8'($urandom_range(255)),
                 16'($urandom_range(16'hFFFF)), $urandom(), 8'($urandom_range(255)));
      end
      // cut some datagrams short at a random point
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(dgram.size(), 1);
        while (dgram.size() > cut) void'(dgram.pop_back());
      end
    end
  endfunction

  // Send the current datagram and queue its expected mapping
  task automatic send_dgram(input bit use_typed, input mapping_t typed);
    mapping_t m;
    bit is_last;
    for (int i = 0; i < dgram.size(); i++) begin
      is_last = (i == dgram.size() - 1);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
        byte_valid <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      byte_valid <= 1'b1;
      byte_data  <= dgram[i];
      byte_last  <= is_last;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      walk_byte(dgram[i]);
      bytes_sent++;
      if (is_last) begin
        m = close_dgram();
        pending_maps.push_back(use_typed ? typed : m);
      end
    end
    dgrams_sent++;
  endtask

  // Hold the sender until every queued mapping has come out
  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (pending_maps.size() != 0);
  endtask

  // Result channel backpressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      res_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  function void check_field(input string fname, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    mapping_t want;
    if (rst_n && out_ch.valid && res_ready) begin
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result with nothing expected, expected none, got found=%b short=%b",
                   $time, out_ch.found, out_ch.too_short);
      end else begin
        want = pending_maps.pop_front();
        check_field("found", 32'(want.found), 32'(out_ch.found));
        check_field("too_short", 32'(want.too_short), 32'(out_ch.too_short));
        check_field("addr_family", 32'(want.addr_family), 32'(out_ch.addr_family));
        check_field("public_port", 32'(want.public_port), 32'(out_ch.public_port));
        check_field("public_addr", want.public_addr, out_ch.public_addr);
        results_checked++;
        if (want.found) found_count++;
        if (want.too_short) short_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned rand_bytes;
    int unsigned stage;
    clear_walker();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed datagrams
    gap_pct   = 15;
    stall_pct = 25;
    for (int p = 0; p < NumProbes; p++) begin
      build_probe(probes[p]);
      send_dgram(probes[p].typed, probes[p].want);
    end
    drain();

    // Random datagrams in stages of changing pressure
    rand_bytes = 0;
    while (rand_bytes < RandomBytes) begin
      stage     = rand_bytes * 4 / RandomBytes;
      gap_pct   = stage_gap[stage];
      stall_pct = stage_stall[stage];
      build_random();
      send_dgram(1'b0, NO_MAP);
      rand_bytes += dgram.size();
      if (dgrams_sent % 16 == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d datagrams, %0d bytes; checked %0d results", dgrams_sent, bytes_sent,
             results_checked);
    $display("Mappings decoded: %0d, short datagrams: %0d", found_count, short_count);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
